// ===== rtl/csvs_pkg.sv =====
package csvs_pkg;

  localparam int unsigned TEXT_BYTES = 16384;
  localparam int unsigned POS_W      = $clog2(TEXT_BYTES);
  localparam int unsigned REC_W      = 10;

  localparam logic [POS_W-1:0] POS_LAST        = POS_W'(TEXT_BYTES - 1);
  localparam logic [REC_W-1:0] MAX_RECORDS_RST = REC_W'(1000);

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [3:0] {
    PH_REC,
    PH_FRONT_U,
    PH_FRONT_Q,
    PH_FRONT_QQ,
    PH_BACK_START,
    PH_BACK_U,
    PH_BACK_Q,
    PH_BACK_QQ,
    PH_AFTER_CR,
    PH_DONE
  } phase_e;

  typedef enum logic [1:0] {
    CAUSE_END_OF_TEXT,
    CAUSE_NO_COMMA,
    CAUSE_REC_LIMIT,
    CAUSE_TOO_LONG
  } cause_e;

  typedef enum logic {
    KIND_RECORD,
    KIND_FINISH
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [REC_W-1:0] record_number;
    logic [POS_W-1:0] front_start;
    logic [POS_W-1:0] front_length;
    logic [POS_W-1:0] back_start;
    logic [POS_W-1:0] back_length;
    cause_e           stop_cause;
    logic             last;
  } result_t;

  function automatic logic is_blank(input logic [7:0] b);
    return (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
  endfunction

endpackage

// ===== rtl/csvs_parser.sv =====
module csvs_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           go_i,
  input  logic [7:0]                     byte_i,
  input  logic [csvs_pkg::REC_W-1:0]     max_records_i,
  output logic [1:0]                     push_o,
  output csvs_pkg::result_t              res0_o,
  output csvs_pkg::result_t              res1_o
);
  import csvs_pkg::*;

  phase_e           ph_q, ph_d, ph_n;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [REC_W-1:0] kept_q, kept_d, kept_nx;
  logic [POS_W-1:0] ff_q, ff_d, fl_q, fl_d, bf_q, bf_d, bl_q, bl_d;
  logic             fs_q, fs_d, bs_q, bs_d;

  // decoded actions for the current byte
  logic   close_req, keep_rec, clear_seen, fin, rearm, adv_pos;
  logic   note_f, note_b, dq, begin_req, fu_req;
  cause_e cause;
  logic   fs_base, bs_base;

  always_comb begin
    ph_n       = ph_q;
    close_req  = 1'b0;
    fin        = 1'b0;
    cause      = CAUSE_END_OF_TEXT;
    rearm      = 1'b0;
    adv_pos    = 1'b0;
    note_f     = 1'b0;
    note_b     = 1'b0;
    dq         = 1'b0;
    begin_req  = 1'b0;
    fu_req     = 1'b0;
    clear_seen = 1'b0;

    if (byte_i == CH_NUL) begin
      rearm = 1'b1;
      case (ph_q)
        PH_REC, PH_AFTER_CR: fin = 1'b1;
        PH_FRONT_U, PH_FRONT_Q, PH_FRONT_QQ: begin
          fin   = 1'b1;
          cause = CAUSE_NO_COMMA;
        end
        PH_DONE: ;
        default: begin
          close_req = 1'b1;
          fin       = 1'b1;
        end
      endcase
    end else if (ph_q == PH_DONE) begin
      ph_n = PH_DONE;
    end else if (pos_q >= POS_LAST) begin
      fin   = 1'b1;
      cause = CAUSE_TOO_LONG;
    end else begin
      adv_pos = 1'b1;
      case (ph_q)
        PH_REC:      begin_req = 1'b1;
        PH_AFTER_CR: begin
          if (byte_i == CH_LF) ph_n = PH_REC;
          else                 begin_req = 1'b1;
        end
        PH_FRONT_U:  fu_req = 1'b1;
        PH_FRONT_Q: begin
          if (byte_i == CH_QUOTE) ph_n = PH_FRONT_QQ;
          else                    note_f = 1'b1;
        end
        PH_FRONT_QQ: begin
          if (byte_i == CH_QUOTE) begin
            note_f = 1'b1;
            dq     = 1'b1;
            ph_n   = PH_FRONT_Q;
          end else if (byte_i == CH_COMMA) begin
            ph_n = PH_BACK_START;
          end else begin
            fin   = 1'b1;
            cause = CAUSE_NO_COMMA;
          end
        end
        PH_BACK_START, PH_BACK_U: begin
          if (ph_q == PH_BACK_START && byte_i == CH_QUOTE) begin
            ph_n = PH_BACK_Q;
          end else if (byte_i == CH_CR) begin
            close_req = 1'b1;
            ph_n      = PH_AFTER_CR;
          end else if (byte_i == CH_LF) begin
            close_req = 1'b1;
            ph_n      = PH_REC;
          end else begin
            note_b = 1'b1;
            ph_n   = PH_BACK_U;
          end
        end
        PH_BACK_Q: begin
          if (byte_i == CH_QUOTE) ph_n = PH_BACK_QQ;
          else                    note_b = 1'b1;
        end
        PH_BACK_QQ: begin
          if (byte_i == CH_QUOTE) begin
            note_b = 1'b1;
            dq     = 1'b1;
            ph_n   = PH_BACK_Q;
          end else begin
            close_req = 1'b1;
            if (byte_i == CH_CR)      ph_n = PH_AFTER_CR;
            else if (byte_i == CH_LF) ph_n = PH_REC;
            else                      begin_req = 1'b1;
          end
        end
        default: ph_n = PH_DONE;
      endcase
    end

    keep_rec = close_req & fs_q & bs_q;
    kept_nx  = kept_q + REC_W'(keep_rec);
    if (close_req) clear_seen = 1'b1;

    // limit is checked against the count after a record closed on this byte
    if (begin_req) begin
      if (kept_nx >= max_records_i) begin
        fin   = 1'b1;
        cause = CAUSE_REC_LIMIT;
      end else begin
        clear_seen = 1'b1;
        if (byte_i == CH_QUOTE) ph_n = PH_FRONT_Q;
        else                    fu_req = 1'b1;
      end
    end

    if (fu_req) begin
      if (byte_i == CH_COMMA) begin
        ph_n = PH_BACK_START;
      end else if (byte_i == CH_CR || byte_i == CH_LF) begin
        fin   = 1'b1;
        cause = CAUSE_NO_COMMA;
      end else begin
        note_f = 1'b1;
        ph_n   = PH_FRONT_U;
      end
    end

    if (!dq && is_blank(byte_i)) begin
      note_f = 1'b0;
      note_b = 1'b0;
    end
    if (fin) ph_n = PH_DONE;
  end

  // next state
  always_comb begin
    fs_base = clear_seen ? 1'b0 : fs_q;
    bs_base = clear_seen ? 1'b0 : bs_q;
    ph_d    = ph_n;
    pos_d   = adv_pos ? pos_q + POS_W'(1) : pos_q;
    kept_d  = kept_nx;
    ff_d    = ff_q;
    fl_d    = fl_q;
    fs_d    = fs_base;
    bf_d    = bf_q;
    bl_d    = bl_q;
    bs_d    = bs_base;
    if (note_f) begin
      if (!fs_base) ff_d = dq ? pos_q - POS_W'(1) : pos_q;
      fl_d = pos_q;
      fs_d = 1'b1;
    end
    if (note_b) begin
      if (!bs_base) bf_d = dq ? pos_q - POS_W'(1) : pos_q;
      bl_d = pos_q;
      bs_d = 1'b1;
    end
    if (rearm) begin
      ph_d   = PH_REC;
      pos_d  = '0;
      kept_d = '0;
      ff_d   = '0;
      fl_d   = '0;
      fs_d   = 1'b0;
      bf_d   = '0;
      bl_d   = '0;
      bs_d   = 1'b0;
    end
  end

  // results
  always_comb begin
    result_t desc, done;
    desc = '0;
    desc.kind          = KIND_RECORD;
    desc.record_number = kept_q;
    desc.front_start   = ff_q;
    desc.front_length  = fl_q - ff_q + POS_W'(1);
    desc.back_start    = bf_q;
    desc.back_length   = bl_q - bf_q + POS_W'(1);
    desc.stop_cause    = CAUSE_END_OF_TEXT;
    desc.last          = ~fin;
    done = '0;
    done.kind          = KIND_FINISH;
    done.record_number = kept_nx;
    done.stop_cause    = cause;
    done.last          = 1'b1;

    res0_o = keep_rec ? desc : done;
    res1_o = done;
    push_o = '0;
    if (go_i) begin
      push_o[0] = keep_rec | fin;
      push_o[1] = keep_rec & fin;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_REC;
      pos_q  <= '0;
      kept_q <= '0;
      ff_q   <= '0;
      fl_q   <= '0;
      fs_q   <= 1'b0;
      bf_q   <= '0;
      bl_q   <= '0;
      bs_q   <= 1'b0;
    end else if (go_i) begin
      ph_q   <= ph_d;
      pos_q  <= pos_d;
      kept_q <= kept_d;
      ff_q   <= ff_d;
      fl_q   <= fl_d;
      fs_q   <= fs_d;
      bf_q   <= bf_d;
      bl_q   <= bl_d;
      bs_q   <= bs_d;
    end
  end

endmodule

// ===== rtl/csvs_result_fifo.sv =====
module csvs_result_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        push_i,
  input  csvs_pkg::result_t res0_i,
  input  csvs_pkg::result_t res1_i,
  input  logic              pop_i,
  output logic              room2_o,
  output logic              valid_o,
  output csvs_pkg::result_t head_o
);
  import csvs_pkg::*;

  localparam int unsigned DEPTH = 4;
  localparam int unsigned AW    = $clog2(DEPTH);

  result_t         mem_q [DEPTH];
  logic [AW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [AW:0]     cnt_q, cnt_d;
  logic            pop;

  assign pop     = pop_i & valid_o;
  assign valid_o = (cnt_q != '0);
  assign room2_o = (cnt_q <= (AW+1)'(DEPTH - 2));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q + AW'(push_i[0]) + AW'(push_i[1]);
    rd_d  = rd_q + AW'(pop);
    cnt_d = cnt_q + (AW+1)'(push_i[0]) + (AW+1)'(push_i[1]) - (AW+1)'(pop);
  end

  // second result always follows the first
  always_ff @(posedge clk_i) begin
    if (push_i[0]) mem_q[wr_q] <= res0_i;
    if (push_i[1]) mem_q[wr_q + AW'(1)] <= res1_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== rtl/two_column_csv_record_splitter_top.sv =====
// channel   dir  handshake              payload
// text      in   in_valid_i/in_stall_o   text_byte_i
// result    out  out_valid_o/out_stall_i kind_o .. last_o
// config    in   max_records_we_i        max_records_i
//
// one text byte per cycle unless stalled: byte register, parse logic, result queue
// every byte waits in its register until the 4-entry queue has room for two
// reset clears the parse state, the queue and sets the record limit to 1000
// a stalled result side backs up through the queue and then stalls the text side
module two_column_csv_record_splitter_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [7:0]                 text_byte_i,
  input  logic                       max_records_we_i,
  input  logic [csvs_pkg::REC_W-1:0] max_records_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       kind_o,
  output logic [csvs_pkg::REC_W-1:0] record_number_o,
  output logic [csvs_pkg::POS_W-1:0] front_start_o,
  output logic [csvs_pkg::POS_W-1:0] front_length_o,
  output logic [csvs_pkg::POS_W-1:0] back_start_o,
  output logic [csvs_pkg::POS_W-1:0] back_length_o,
  output logic [1:0]                 stop_cause_o,
  output logic                       last_o
);
  import csvs_pkg::*;

  logic [7:0]       byte_q;
  logic             byte_vld_q;
  logic [REC_W-1:0] max_rec_q;
  logic             room2, go, take;
  logic [1:0]       push;
  result_t          res0, res1, head;

  assign go         = byte_vld_q & room2;
  assign in_stall_o = byte_vld_q & ~room2;
  assign take       = in_valid_i & ~in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_vld_q <= 1'b0;
      max_rec_q  <= MAX_RECORDS_RST;
    end else begin
      byte_vld_q <= take | (byte_vld_q & ~go);
      if (max_records_we_i) max_rec_q <= max_records_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) byte_q <= text_byte_i;
  end

  csvs_parser u_parser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .go_i          (go),
    .byte_i        (byte_q),
    .max_records_i (max_rec_q),
    .push_o        (push),
    .res0_o        (res0),
    .res1_o        (res1)
  );

  csvs_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res0_i  (res0),
    .res1_i  (res1),
    .pop_i   (~out_stall_i),
    .room2_o (room2),
    .valid_o (out_valid_o),
    .head_o  (head)
  );

  assign kind_o          = head.kind;
  assign record_number_o = head.record_number;
  assign front_start_o   = head.front_start;
  assign front_length_o  = head.front_length;
  assign back_start_o    = head.back_start;
  assign back_length_o   = head.back_length;
  assign stop_cause_o    = head.stop_cause;
  assign last_o          = head.last;

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import csvs_pkg::*;

  localparam int SETTLE_CYCLES = 12;
  localparam int QUIET_LIMIT   = 5000;
  localparam int REPORT_LIMIT  = 10;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  logic [7:0]       text_byte_i = 8'h00;
  logic             max_records_we_i = 1'b0;
  logic [REC_W-1:0] max_records_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             kind_o;
  logic [REC_W-1:0] record_number_o;
  logic [POS_W-1:0] front_start_o;
  logic [POS_W-1:0] front_length_o;
  logic [POS_W-1:0] back_start_o;
  logic [POS_W-1:0] back_length_o;
  logic [1:0]       stop_cause_o;
  logic             last_o;

  two_column_csv_record_splitter_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .text_byte_i     (text_byte_i),
    .max_records_we_i(max_records_we_i),
    .max_records_i   (max_records_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .kind_o          (kind_o),
    .record_number_o (record_number_o),
    .front_start_o   (front_start_o),
    .front_length_o  (front_length_o),
    .back_start_o    (back_start_o),
    .back_length_o   (back_length_o),
    .stop_cause_o    (stop_cause_o),
    .last_o          (last_o)
  );

  always #2 clk_i = ~clk_i;

  int idle_pct = 0;
  int stall_pct = 0;
  int bytes_sent = 0;
  int results_checked = 0;
  int mismatch_count = 0;
  int quiet_cycles = 0;

  result_t pending_results[$];
  result_t fresh_results[$];

  // parser mirror
  phase_e           parse_phase;
  logic [POS_W-1:0] text_pos;
  logic [REC_W-1:0] kept_total;
  logic [REC_W-1:0] record_limit = MAX_RECORDS_RST;
  logic [POS_W-1:0] front_lo, front_hi, back_lo, back_hi;
  logic             front_any, back_any;

  function automatic void reset_parse();
    parse_phase = PH_REC;
    text_pos    = '0;
    kept_total  = '0;
    front_lo    = '0;
    front_hi    = '0;
    front_any   = 1'b0;
    back_lo     = '0;
    back_hi     = '0;
    back_any    = 1'b0;
  endfunction

  function automatic void emit(input kind_e k, input logic [REC_W-1:0] rec,
                               input logic [POS_W-1:0] fs, input logic [POS_W-1:0] fl,
                               input logic [POS_W-1:0] bs, input logic [POS_W-1:0] bl,
                               input cause_e cause);
    result_t r;
    r.kind          = k;
    r.record_number = rec;
    r.front_start   = fs;
    r.front_length  = fl;
    r.back_start    = bs;
    r.back_length   = bl;
    r.stop_cause    = cause;
    r.last          = 1'b0;
    fresh_results.push_back(r);
  endfunction

  // remember first and last non-blank offsets of a field
  function automatic void mark_content(input logic [7:0] b, input logic [POS_W-1:0] p,
                                       input bit back);
    if (b == CH_SPACE || b == CH_TAB || b == CH_CR || b == CH_LF)
      return;
    if (back) begin
      if (!back_any) begin
        back_lo  = p;
        back_any = 1'b1;
      end
      back_hi = p;
    end else begin
      if (!front_any) begin
        front_lo  = p;
        front_any = 1'b1;
      end
      front_hi = p;
    end
  endfunction

  function automatic void stop_parse(input cause_e cause);
    emit(KIND_FINISH, kept_total, '0, '0, '0, '0, cause);
    parse_phase = PH_DONE;
  endfunction

  function automatic void close_pair();
    if (front_any && back_any) begin
      emit(KIND_RECORD, kept_total, front_lo, front_hi - front_lo + 1'b1,
           back_lo, back_hi - back_lo + 1'b1, CAUSE_END_OF_TEXT);
      kept_total = kept_total + 1'b1;
    end
    front_any = 1'b0;
    back_any  = 1'b0;
  endfunction

  function automatic void front_plain(input logic [7:0] b);
    if (b == CH_COMMA) begin
      parse_phase = PH_BACK_START;
    end else if (b == CH_CR || b == CH_LF) begin
      stop_parse(CAUSE_NO_COMMA);
    end else begin
      mark_content(b, text_pos, 1'b0);
      parse_phase = PH_FRONT_U;
    end
  endfunction

  function automatic void open_record(input logic [7:0] b);
    if (kept_total >= record_limit) begin
      stop_parse(CAUSE_REC_LIMIT);
      return;
    end
    front_any = 1'b0;
    back_any  = 1'b0;
    if (b == CH_QUOTE)
      parse_phase = PH_FRONT_Q;
    else
      front_plain(b);
  endfunction

  function automatic void back_plain(input logic [7:0] b);
    if (b == CH_CR) begin
      close_pair();
      parse_phase = PH_AFTER_CR;
    end else if (b == CH_LF) begin
      close_pair();
      parse_phase = PH_REC;
    end else begin
      mark_content(b, text_pos, 1'b1);
      parse_phase = PH_BACK_U;
    end
  endfunction

  function automatic void text_end();
    case (parse_phase)
      PH_REC, PH_AFTER_CR: stop_parse(CAUSE_END_OF_TEXT);
      PH_FRONT_U, PH_FRONT_Q, PH_FRONT_QQ: stop_parse(CAUSE_NO_COMMA);
      PH_DONE: ;
      default: begin
        close_pair();
        stop_parse(CAUSE_END_OF_TEXT);
      end
    endcase
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    logic [POS_W-1:0] p;
    result_t          tail;
    p = text_pos;
    fresh_results.delete();
    if (b == CH_NUL) begin
      text_end();
      reset_parse();
    end else if (parse_phase != PH_DONE) begin
      if (text_pos >= POS_LAST) begin
        stop_parse(CAUSE_TOO_LONG);
      end else begin
        case (parse_phase)
          PH_REC: open_record(b);
          PH_AFTER_CR: begin
            if (b == CH_LF)
              parse_phase = PH_REC;
            else
              open_record(b);
          end
          PH_FRONT_U: front_plain(b);
          PH_FRONT_Q: begin
            if (b == CH_QUOTE)
              parse_phase = PH_FRONT_QQ;
            else
              mark_content(b, p, 1'b0);
          end
          PH_FRONT_QQ: begin
            if (b == CH_QUOTE) begin
              // doubled quote stays in the field as two bytes
              mark_content(CH_QUOTE, p - 1'b1, 1'b0);
              mark_content(CH_QUOTE, p, 1'b0);
              parse_phase = PH_FRONT_Q;
            end else if (b == CH_COMMA) begin
              parse_phase = PH_BACK_START;
            end else begin
              stop_parse(CAUSE_NO_COMMA);
            end
          end
          PH_BACK_START: begin
            if (b == CH_QUOTE)
              parse_phase = PH_BACK_Q;
            else
              back_plain(b);
          end
          PH_BACK_U: back_plain(b);
          PH_BACK_Q: begin
            if (b == CH_QUOTE)
              parse_phase = PH_BACK_QQ;
            else
              mark_content(b, p, 1'b1);
          end
          PH_BACK_QQ: begin
            if (b == CH_QUOTE) begin
              mark_content(CH_QUOTE, p - 1'b1, 1'b1);
              mark_content(CH_QUOTE, p, 1'b1);
              parse_phase = PH_BACK_Q;
            end else begin
              close_pair();
              if (b == CH_CR)
                parse_phase = PH_AFTER_CR;
              else if (b == CH_LF)
                parse_phase = PH_REC;
              else
                open_record(b);
            end
          end
          default: parse_phase = PH_DONE;
        endcase
        text_pos = p + 1'b1;
      end
    end
    if (fresh_results.size() != 0) begin
      tail      = fresh_results.pop_back();
      tail.last = 1'b1;
      fresh_results.push_back(tail);
      foreach (fresh_results[i])
        pending_results.push_back(fresh_results[i]);
    end
  endfunction

  // result side: check what is taken, then pick the next stall
  always @(posedge clk_i) begin : result_check
    result_t got;
    result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.kind          = kind_e'(kind_o);
      got.record_number = record_number_o;
      got.front_start   = front_start_o;
      got.front_length  = front_length_o;
      got.back_start    = back_start_o;
      got.back_length   = back_length_o;
      got.stop_cause    = cause_e'(stop_cause_o);
      got.last          = last_o;
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: result with nothing expected: kind %0d rec %0d cause %0d",
                   $realtime, got.kind, got.record_number, got.stop_cause);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_LIMIT) begin
            $display("%0t: expected kind %0d rec %0d front %0d+%0d back %0d+%0d cause %0d last %0d",
                     $realtime, want.kind, want.record_number, want.front_start,
                     want.front_length, want.back_start, want.back_length,
                     want.stop_cause, want.last);
            $display("%0t: actual   kind %0d rec %0d front %0d+%0d back %0d+%0d cause %0d last %0d",
                     $realtime, got.kind, got.record_number, got.front_start,
                     got.front_length, got.back_start, got.back_length,
                     got.stop_cause, got.last);
          end
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("%0t: no request or result moved for %0d cycles, %0d results outstanding",
             $realtime, QUIET_LIMIT, pending_results.size());
    $display("** two_column_csv_record_splitter_top: FAILED **");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    text_byte_i <= b;
    // hold the request until it is taken
    do @(posedge clk_i); while (in_stall_o);
    bytes_sent++;
    parse_byte(b);
  endtask

  task automatic send_line(input string s);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i]);
    send_byte(CH_NUL);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0)
      @(posedge clk_i);
    // bytes with no result may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [REC_W-1:0] value);
    wait_drained();
    max_records_we_i <= 1'b1;
    max_records_i    <= value;
    @(posedge clk_i);
    max_records_we_i <= 1'b0;
    record_limit = value;
  endtask

  function automatic logic [7:0] field_char(input bit quoted);
    logic [7:0] c;
    case ($urandom_range(7))
      0: c = $urandom_range(1) ? CH_SPACE : CH_TAB;
      1: begin
        if (!quoted)
          c = CH_SPACE;
        else
          case ($urandom_range(2))
            0: c = CH_COMMA;
            1: c = CH_CR;
            default: c = CH_LF;
          endcase
      end
      default: begin
        do
          c = 8'($urandom_range(1, 255));
        while (c == CH_QUOTE ||
               (!quoted && (c == CH_COMMA || c == CH_CR || c == CH_LF)));
      end
    endcase
    return c;
  endfunction

  task automatic send_field();
    int len;
    bit quoted;
    len    = $urandom_range(0, 5);
    quoted = ($urandom_range(2) == 0);
    if (quoted)
      send_byte(CH_QUOTE);
    repeat (len) begin
      if (quoted && $urandom_range(5) == 0) begin
        send_byte(CH_QUOTE);
        send_byte(CH_QUOTE);
      end else begin
        send_byte(field_char(quoted));
      end
    end
    if (quoted)
      send_byte(CH_QUOTE);
  endtask

  // mostly well-formed records with the odd stray byte, missing comma or cut text
  task automatic send_random_text();
    int records;
    records = $urandom_range(1, 10);
    for (int r = 0; r < records; r++) begin
      case ($urandom_range(29))
        0: send_byte(8'($urandom_range(1, 255)));
        1: begin
          send_field();
          send_byte(CH_NUL);
          return;
        end
        default: ;
      endcase
      send_field();
      if ($urandom_range(29) != 0)
        send_byte(CH_COMMA);
      send_field();
      case ($urandom_range(3))
        0: send_byte(CH_LF);
        1: begin
          send_byte(CH_CR);
          send_byte(CH_LF);
        end
        2: send_byte(CH_CR);
        default: ;
      endcase
    end
    send_byte(CH_NUL);
  endtask

  task automatic test_directed_cases();
    idle_pct  = 0;
    stall_pct = 0;
    send_line("");
    // doubled quotes in both fields, quoted back running into the next record,
    // blank front dropped, text ending inside the back field with no line end
    send_line("\"a\"\"\",\"b\"\"\"x,y\r\n \t,z");
    send_line("\377q\001,\"w\"\r\n");
    // quoted front not followed by a comma, then ignored bytes
    send_line("\"a\"b,c");
    send_line("ab");
    send_line("\n");
    send_line(" k\r");
  endtask

  task automatic test_record_limit();
    idle_pct  = 0;
    stall_pct = 20;
    write_limit(10'd1);
    send_line("a,b\nc,d\n");
    send_line("a,b\n");
    write_limit(10'd1000);
    send_line("c,d\n");
  endtask

  task automatic test_random_text(input int send_idle, input int recv_stall,
                                  input logic [REC_W-1:0] limit, input int byte_goal);
    int first;
    write_limit(limit);
    idle_pct  = send_idle;
    stall_pct = recv_stall;
    first     = bytes_sent;
    while (bytes_sent - first < byte_goal) begin
      send_random_text();
      if ($urandom_range(7) == 0)
        wait_drained();
    end
  endtask

  initial begin
    reset_parse();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_record_limit();
    test_random_text(0, 0, 10'd1000, 240);
    test_random_text(61, 0, 10'd23, 240);
    test_random_text(0, 61, 10'd5, 240);
    test_random_text(8, 8, 10'($urandom_range(2, 999)), 240);
    wait_drained();
    $display("covered %0d text bytes, %0d results checked: quoting, trimming,",
             bytes_sent, results_checked);
    $display("end of text, missing comma and record limit stops, four request/stall mixes");
    if (mismatch_count == 0)
      $display("** two_column_csv_record_splitter_top: PASSED **");
    else
      $display("** two_column_csv_record_splitter_top: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/csvs_pkg.sv
rtl/csvs_parser.sv
rtl/csvs_result_fifo.sv
rtl/two_column_csv_record_splitter_top.sv
test/testbench.sv
